// ----- rtl/msbb_pkg.sv -----
// Shared constants and types for the median string branch-and-bound unit.
package msbb_pkg;

	localparam int MAX_SEQUENCES  = 16;
	localparam int MAX_SEQ_LENGTH = 256;
	localparam int MAX_LMER       = 16;

	localparam logic [1:0] TOP_BASE       = 2'd3;
	localparam logic [8:0] TOTAL_ALL_ONES = 9'd511;

	localparam logic [1:0] REG_LMER_LENGTH   = 2'd0;
	localparam logic [1:0] REG_NUM_SEQUENCES = 2'd1;
	localparam logic [1:0] REG_SEQ_LENGTH    = 2'd2;
	localparam logic [1:0] REG_NONE          = 2'd3;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_START = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SEQ,
		ST_WIN,
		ST_RD,
		ST_CMP,
		ST_WEND,
		ST_SEND,
		ST_DECIDE,
		ST_SIB,
		ST_OUT
	} state_t;

	// scorer request from top level to score engine
	typedef struct packed {
		logic       start;
		logic [5:0] len;
		logic [5:0] plen;
		logic [6:0] nseq;
		logic [12:0] slen;
	} score_req_t;

endpackage

// ----- rtl/median_string_branch_bound_unit.sv -----
// Top level: stream ports, tree walk sequencer and result register.
// Load beats (mode 0) are taken one per cycle while idle and write one base into the
// sequence store when seq_index and base_position are in range. A start beat (mode 1)
// runs the depth-first walk; each scored prefix of k bases is compared with every window
// of each sequence, W = seq_length - lmer_length + 1 windows (none when the sequence is
// shorter). The block takes no beat during the walk. The result beat waits in its own
// register until taken; loads and the next start are taken meanwhile, and a following
// search holds in its output state until that register is free.
module median_string_branch_bound_unit #(
	parameter int MAX_SEQUENCES  = msbb_pkg::MAX_SEQUENCES,
	parameter int MAX_SEQ_LENGTH = msbb_pkg::MAX_SEQ_LENGTH,
	parameter int MAX_LMER       = msbb_pkg::MAX_LMER,
	localparam int SW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1,
	localparam int PW = $clog2(MAX_SEQ_LENGTH)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[0], seq_index[4:1], base_position[12:5], base[14:13], zero fill[15]
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pattern[31:0], total distance[40:32], zero fill[47:41]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int TW = $clog2(MAX_LMER + 1);
	localparam int LW = $clog2(MAX_LMER);

	logic [4:0] lmer_q, nseq_q;
	logic [8:0] slen_q;
	logic [1:0] pat_q [MAX_LMER];
	logic [2*MAX_LMER-1:0] pat_flat;
	logic [TW-1:0] lvl_q, plen;
	logic [LW-1:0] lvl_m1;
	logic [31:0] best_pat_q;
	logic [8:0]  best_q;
	logic [31:0] res_word_q;
	logic [8:0]  res_dist_q;
	msbb_pkg::state_t st_q, st_d;
	msbb_pkg::score_req_t req;
	logic sdone;
	logic [8:0] stotal;
	logic out_v_q;
	logic res_load;
	logic in_acc;
	logic ld_ok;
	logic [31:0] packed_w;

	logic       in_mode;
	logic [3:0] in_seq;
	logic [7:0] in_pos;
	logic [1:0] in_base;
	assign in_mode = s_axis_tdata[0];
	assign in_seq  = s_axis_tdata[4:1];
	assign in_pos  = s_axis_tdata[12:5];
	assign in_base = s_axis_tdata[14:13];

	assign s_axis_tready = (st_q == msbb_pkg::ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign ld_ok = (32'(in_seq) < MAX_SEQUENCES) && (32'(in_pos) < MAX_SEQ_LENGTH);
	assign lvl_m1 = LW'(lvl_q - TW'(1));
	assign res_load = (st_q == msbb_pkg::ST_OUT) && (!out_v_q || m_axis_tready);

	always_comb begin
		if (lmer_q == 5'd0) plen = TW'(1);
		else if (32'(lmer_q) > MAX_LMER) plen = TW'(MAX_LMER);
		else plen = TW'(lmer_q);
	end

	always_comb begin
		packed_w = '0;
		for (int i = 0; i < MAX_LMER; i++) begin
			pat_flat[2*i +: 2] = pat_q[i];
			if (i < 16 && i < 32'(plen)) packed_w[2*(i%16) +: 2] = pat_q[i];
		end
	end

	assign req.start = (st_q == msbb_pkg::ST_SEQ);
	assign req.len   = 6'(lvl_q);
	assign req.plen  = 6'(plen);
	assign req.nseq  = (32'(nseq_q) > MAX_SEQUENCES) ? 7'(MAX_SEQUENCES) : 7'(nseq_q);
	assign req.slen  = (32'(slen_q) > MAX_SEQ_LENGTH) ? 13'(MAX_SEQ_LENGTH) : 13'(slen_q);

	msbb_score #(
		.MAX_SEQUENCES (MAX_SEQUENCES),
		.MAX_SEQ_LENGTH(MAX_SEQ_LENGTH),
		.MAX_LMER      (MAX_LMER)
	) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pattern(pat_flat),
		.wr_en  (in_acc && in_mode == msbb_pkg::MODE_LOAD && ld_ok),
		.wr_addr({SW'(in_seq), PW'(in_pos)}),
		.wr_data(in_base),
		.done   (sdone),
		.total  (stotal)
	);

	// ST_SEQ issues a score, ST_WIN waits for it, ST_SIB scans for a sibling
	always_comb begin
		st_d = st_q;
		case (st_q)
			msbb_pkg::ST_IDLE:
				if (in_acc && in_mode == msbb_pkg::MODE_START) st_d = msbb_pkg::ST_INIT;
			msbb_pkg::ST_INIT: st_d = msbb_pkg::ST_SEQ;
			msbb_pkg::ST_SEQ:  st_d = msbb_pkg::ST_WIN;
			msbb_pkg::ST_WIN:  if (sdone) st_d = msbb_pkg::ST_DECIDE;
			msbb_pkg::ST_DECIDE: begin
				if (lvl_q < plen && stotal > best_q) st_d = msbb_pkg::ST_SIB;
				else if (lvl_q < plen) st_d = msbb_pkg::ST_SEQ;
				else st_d = msbb_pkg::ST_SIB;
			end
			msbb_pkg::ST_SIB: begin
				if (lvl_q == '0) st_d = msbb_pkg::ST_OUT;
				else if (pat_q[lvl_m1] < msbb_pkg::TOP_BASE) st_d = msbb_pkg::ST_SEQ;
			end
			// hold until the result register is free
			msbb_pkg::ST_OUT: if (res_load) st_d = msbb_pkg::ST_IDLE;
			default: st_d = msbb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= msbb_pkg::ST_IDLE;
			lmer_q      <= 5'd8;
			nseq_q      <= 5'd16;
			slen_q      <= 9'd256;
			lvl_q       <= TW'(1);
			best_q      <= msbb_pkg::TOTAL_ALL_ONES;
			best_pat_q  <= '0;
			res_word_q  <= '0;
			res_dist_q  <= '0;
			out_v_q     <= 1'b0;
			for (int i = 0; i < MAX_LMER; i++) pat_q[i] <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_index)
					msbb_pkg::REG_LMER_LENGTH:   lmer_q <= cfg_data[4:0];
					msbb_pkg::REG_NUM_SEQUENCES: nseq_q <= cfg_data[4:0];
					msbb_pkg::REG_SEQ_LENGTH:    slen_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) begin
				out_v_q    <= 1'b1;
				res_word_q <= best_pat_q;
				res_dist_q <= best_q;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				msbb_pkg::ST_INIT: begin
					for (int i = 0; i < MAX_LMER; i++) pat_q[i] <= '0;
					lvl_q       <= TW'(1);
					best_q      <= msbb_pkg::TOTAL_ALL_ONES;
					best_pat_q  <= '0;
				end
				msbb_pkg::ST_DECIDE: begin
					if (lvl_q < plen) begin
						if (!(stotal > best_q)) begin
							pat_q[LW'(lvl_q)] <= '0;
							lvl_q <= lvl_q + TW'(1);
						end
					end else if (stotal < best_q) begin
						best_q      <= stotal;
						best_pat_q  <= packed_w;
					end
				end
				msbb_pkg::ST_SIB: begin
					// step down one level per cycle until a base can advance
					if (lvl_q != '0) begin
						if (pat_q[lvl_m1] < msbb_pkg::TOP_BASE)
							pat_q[lvl_m1] <= pat_q[lvl_m1] + 2'd1;
						else
							lvl_q <= lvl_q - TW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, res_dist_q, res_word_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != msbb_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= plen || st_q == msbb_pkg::ST_IDLE) else $error("level past pattern");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == msbb_pkg::ST_OUT) |=> out_v_q) else $error("result lost");

endmodule

// ----- rtl/msbb_score.sv -----
// Iterative prefix scorer: compares one base at a time over sequences and windows, and takes no new request until done.
module msbb_score #(
	parameter int MAX_SEQUENCES  = msbb_pkg::MAX_SEQUENCES,
	parameter int MAX_SEQ_LENGTH = msbb_pkg::MAX_SEQ_LENGTH,
	parameter int MAX_LMER       = msbb_pkg::MAX_LMER,
	localparam int SW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1,
	localparam int PW = $clog2(MAX_SEQ_LENGTH),
	localparam int LW = $clog2(MAX_LMER)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msbb_pkg::score_req_t req,
	input  logic [2*MAX_LMER-1:0] pattern,
	input  logic                 wr_en,
	input  logic [SW+PW-1:0]     wr_addr,
	input  logic [1:0]           wr_data,
	output logic                 done,
	output logic [8:0]           total
);

	logic [1:0] mem [MAX_SEQUENCES*MAX_SEQ_LENGTH];
	logic [1:0] rd_q;
	logic [SW+PW-1:0] rd_addr;

	msbb_pkg::state_t st_q, st_d;
	logic [6:0]  s_q;
	logic [12:0] w_q;
	logic [5:0]  j_q;
	logic [5:0]  d_q;
	logic [8:0]  least_q;
	logic [9:0]  total_q;
	logic [13:0] wend;

	assign rd_addr = {s_q[SW-1:0], PW'(w_q + 13'(j_q))};
	assign wend    = 14'(w_q) + 14'(req.plen);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			msbb_pkg::ST_IDLE: if (req.start) st_d = msbb_pkg::ST_SEQ;
			msbb_pkg::ST_SEQ: begin
				if (s_q >= req.nseq) st_d = msbb_pkg::ST_OUT;
				else st_d = msbb_pkg::ST_WIN;
			end
			msbb_pkg::ST_WIN: begin
				// window fits only while w + plen <= slen
				if (wend > 14'(req.slen)) st_d = msbb_pkg::ST_SEND;
				else if (req.len == 6'd0) st_d = msbb_pkg::ST_WEND;
				else st_d = msbb_pkg::ST_RD;
			end
			msbb_pkg::ST_RD: st_d = msbb_pkg::ST_CMP;
			msbb_pkg::ST_CMP: begin
				if (j_q + 6'd1 >= req.len) st_d = msbb_pkg::ST_WEND;
				else st_d = msbb_pkg::ST_RD;
			end
			msbb_pkg::ST_WEND: st_d = msbb_pkg::ST_WIN;
			msbb_pkg::ST_SEND: st_d = msbb_pkg::ST_SEQ;
			msbb_pkg::ST_OUT:  st_d = msbb_pkg::ST_IDLE;
			default: st_d = msbb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= msbb_pkg::ST_IDLE;
			s_q     <= '0;
			w_q     <= '0;
			j_q     <= '0;
			d_q     <= '0;
			least_q <= '0;
			total_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				msbb_pkg::ST_IDLE: begin
					if (req.start) begin
						s_q     <= '0;
						total_q <= '0;
					end
				end
				msbb_pkg::ST_SEQ: begin
					if (s_q < req.nseq) begin
						w_q     <= '0;
						least_q <= msbb_pkg::TOTAL_ALL_ONES;
					end
				end
				msbb_pkg::ST_WIN: begin
					if (!(wend > 14'(req.slen))) begin
						j_q <= '0;
						d_q <= '0;
					end
				end
				msbb_pkg::ST_CMP: begin
					if (rd_q != pattern[2*j_q[LW-1:0] +: 2]) d_q <= d_q + 6'd1;
					j_q <= j_q + 6'd1;
				end
				msbb_pkg::ST_WEND: begin
					if (9'(d_q) < least_q) least_q <= 9'(d_q);
					w_q <= w_q + 13'd1;
				end
				msbb_pkg::ST_SEND: begin
					if (total_q + 10'(least_q) > 10'(msbb_pkg::TOTAL_ALL_ONES))
						total_q <= 10'(msbb_pkg::TOTAL_ALL_ONES);
					else
						total_q <= total_q + 10'(least_q);
					s_q <= s_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	assign done  = (st_q == msbb_pkg::ST_OUT);
	assign total = total_q[8:0];

	a_total_sat: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= 10'(msbb_pkg::TOTAL_ALL_ONES)) else $error("total above saturation");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == msbb_pkg::ST_CMP) |-> (j_q < req.len)) else $error("compare past prefix");

endmodule
